@@ sv/stbi_pkg.sv @@
package stbi_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned IDX_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  // Configuration register indexes (word address bit 2 and up)
  localparam logic REG_KEEP_DUP = 1'b0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_SHIFT,
    ST_PUT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic clear;
    logic probe_rd;
    logic probe_cmp;
    logic shift_init;
    logic shift_step;
    logic put;
    logic set_full;
    logic out_load;
  } stbi_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic search_open;
    logic found;
    logic table_full;
    logic shift_last;
  } stbi_stat_t;

endpackage

@@ sv/stbi_datapath.sv @@
module stbi_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [stbi_pkg::KEY_BITS-1:0]       key_i,
  input  stbi_pkg::stbi_ctrl_t                ctrl_i,
  output stbi_pkg::stbi_stat_t                stat_o,
  output logic                                found_o,
  output logic                                inserted_o,
  output logic [stbi_pkg::CNT_BITS-1:0]       location_o,
  output logic [stbi_pkg::CNT_BITS-1:0]       entry_total_o,
  output logic                                table_full_o
);
  import stbi_pkg::*;

  logic [KEY_BITS-1:0] mem [DEPTH];
  logic [KEY_BITS-1:0] rd_data_q;
  logic [KEY_BITS-1:0] key_q;

  logic [CNT_BITS-1:0] count_q, count_d;
  logic [CNT_BITS-1:0] left_q, hi_q, sh_q;
  logic [IDX_BITS-1:0] wr_idx_q;
  logic                pend_q, pend_d;
  logic                found_q, inserted_q, full_q;

  logic [CNT_BITS:0]   mid_sum;
  logic [CNT_BITS-1:0] mid;
  logic [CNT_BITS-1:0] sh_dec;
  logic                shift_last;

  logic                rd_en, wr_en;
  logic [IDX_BITS-1:0] rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  // middle = (left + right) / 2 with right = hi - 1; left < hi while searching
  assign mid_sum    = {1'b0, left_q} + {1'b0, hi_q} - {{CNT_BITS{1'b0}}, 1'b1};
  assign mid        = mid_sum[CNT_BITS:1];
  assign sh_dec     = sh_q - {{(CNT_BITS-1){1'b0}}, 1'b1};
  assign shift_last = (sh_q == left_q);

  assign stat_o.search_open = (left_q < hi_q);
  assign stat_o.found       = found_q;
  assign stat_o.table_full  = (count_q == CNT_BITS'(DEPTH));
  assign stat_o.shift_last  = shift_last;

  // Memory ports: one read, one write per cycle
  assign rd_en   = ctrl_i.probe_rd | (ctrl_i.shift_step & ~shift_last);
  assign rd_addr = ctrl_i.probe_rd ? mid[IDX_BITS-1:0] : sh_dec[IDX_BITS-1:0];
  assign wr_en   = ctrl_i.put | (ctrl_i.shift_step & pend_q);
  assign wr_addr = ctrl_i.put ? left_q[IDX_BITS-1:0] : wr_idx_q;
  assign wr_data = ctrl_i.put ? key_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    pend_d  = pend_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.put) begin
      count_d = count_q + {{(CNT_BITS-1){1'b0}}, 1'b1};
    end
    if (ctrl_i.shift_init) begin
      pend_d = 1'b0;
    end else if (ctrl_i.shift_step) begin
      pend_d = ~shift_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Search window, shift pointer and result flags
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      key_q      <= key_i;
      left_q     <= '0;
      hi_q       <= count_q;
      found_q    <= 1'b0;
      inserted_q <= 1'b0;
      full_q     <= 1'b0;
    end else begin
      if (ctrl_i.probe_cmp) begin
        if (rd_data_q < key_q) begin
          left_q <= mid + {{(CNT_BITS-1){1'b0}}, 1'b1};
        end else if (rd_data_q > key_q) begin
          hi_q <= mid;
        end else begin
          found_q <= 1'b1;
          left_q  <= mid;
          hi_q    <= mid;
        end
      end
      if (ctrl_i.set_full) begin
        full_q <= 1'b1;
      end
      if (ctrl_i.put) begin
        inserted_q <= 1'b1;
      end
    end
    if (ctrl_i.shift_init) begin
      sh_q <= count_q;
    end else if (ctrl_i.shift_step && !shift_last) begin
      wr_idx_q <= sh_q[IDX_BITS-1:0];
      sh_q     <= sh_dec;
    end
  end

  // Result holding register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      found_o       <= found_q;
      inserted_o    <= inserted_q;
      location_o    <= left_q;
      entry_total_o <= count_q;
      table_full_o  <= full_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("entry count above depth");

  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.put |-> (count_q < CNT_BITS'(DEPTH)) && (left_q <= count_q))
    else $error("insert without room or past the end");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.probe_rd |-> (mid < count_q) && (left_q < hi_q))
    else $error("probe outside the held entries");
`endif

endmodule

@@ sv/stbi_controller.sv @@
module stbi_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stbi_pkg::cmd_e       cmd_i,
  input  logic                 keep_dup_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  stbi_pkg::stbi_stat_t stat_i,
  output stbi_pkg::stbi_ctrl_t ctrl_o
);
  import stbi_pkg::*;

  state_e state_q, state_d;
  cmd_e   cmd_q;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl_o.start = 1'b1;
          unique case (cmd_i)
            CMD_INSERT, CMD_FIND: state_d = ST_PROBE;
            CMD_CLEAR: begin
              ctrl_o.clear = 1'b1;
              state_d      = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_PROBE: begin
        if (stat_i.search_open) begin
          ctrl_o.probe_rd = 1'b1;
          state_d         = ST_COMPARE;
        end else if (cmd_q != CMD_INSERT) begin
          state_d = ST_DONE;
        end else if (stat_i.found && !keep_dup_i) begin
          state_d = ST_DONE;
        end else if (stat_i.table_full) begin
          ctrl_o.set_full = 1'b1;
          state_d         = ST_DONE;
        end else begin
          ctrl_o.shift_init = 1'b1;
          state_d           = ST_SHIFT;
        end
      end
      ST_COMPARE: begin
        ctrl_o.probe_cmp = 1'b1;
        state_d          = ST_PROBE;
      end
      ST_SHIFT: begin
        ctrl_o.shift_step = 1'b1;
        if (stat_i.shift_last) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        ctrl_o.put = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ sv/sorted_table_binary_insert_unit.sv @@
// Sorted key table with halving search and ordered insert.
// Input channel (s_axis_*): tuser[1:0] carries the command (insert, find,
// clear), tdata[31:0] the key. Output channel (m_axis_*): one result
// transaction per command with found, inserted, location, entry total and
// table-full flag. The APB port holds keep_duplicate_keys at address 0.
// A find makes one probe per halving step (at most 7 for 64 entries), each
// probe being a memory read followed by a compare, and then loads its
// result. An insert that stores its key next moves later keys up one place
// per cycle through the key memory (one read and one write a cycle), then
// writes the new key. A clear or an unused command goes straight to loading
// its result. One command is in work at a time and the next is accepted in
// the cycle after the result is loaded; input is ready only while the
// controller is idle, but a finished result sits in an output register, so
// the next command is accepted while the receiver stalls. A stalled receiver
// holds the block in its final step until the register drains.
// Reset empties the table (count to zero) and clears keep_duplicate_keys;
// memory contents are left as they are and only entries below the count
// are ever read.
module sorted_table_binary_insert_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] found, [1] inserted, [8:2] location,
                                      // [15:9] entry_total, [16] table_full
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stbi_pkg::*;

  stbi_ctrl_t          ctrl;
  stbi_stat_t          stat;
  logic                keep_dup_q;
  logic                cfg_wr;
  logic                found, inserted, table_full;
  logic [CNT_BITS-1:0] location, entry_total;

  // APB: always ready, single register at word index 0
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_dup_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_KEEP_DUP) begin
      keep_dup_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEEP_DUP) begin
      prdata[0] = keep_dup_q;
    end
  end

  stbi_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (cmd_e'(s_axis_tuser)),
    .keep_dup_i  (keep_dup_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  stbi_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_i         (s_axis_tdata[KEY_BITS-1:0]),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .found_o       (found),
    .inserted_o    (inserted),
    .location_o    (location),
    .entry_total_o (entry_total),
    .table_full_o  (table_full)
  );

  // Pack result fields, low bit first, zero-fill to three bytes
  assign m_axis_tdata = {7'b0, table_full, entry_total, location, inserted, found};

endmodule
